// File: design/mono_icon_blit_framebuffer_assert.svh
// ----------------------------------------------------------------------------
// mono_icon_blit_framebuffer_assert.svh
// assertion macros used by the blitter checker
// ----------------------------------------------------------------------------
`ifndef MONO_ICON_BLIT_FRAMEBUFFER_ASSERT_SVH
`define MONO_ICON_BLIT_FRAMEBUFFER_ASSERT_SVH

// same-cycle implication, held off during reset
`define MIBF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define MIBF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define MIBF_ASSERT_NXT_ANY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mibf_pkg.sv
// ----------------------------------------------------------------------------
// mibf_pkg
// screen geometry, framebuffer sizing and payload types of the icon blitter
// ----------------------------------------------------------------------------
package mibf_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;
    localparam int FB_BYTES      = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8;
    localparam int FB_AW         = $clog2(FB_BYTES);
    localparam int ICON_DIM_MAX  = 128;
    localparam int CNT_W         = 15;

    // item codes
    localparam logic MODE_BLIT = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef logic [6:0]       t_pos;
    typedef logic [7:0]       t_dim;
    typedef logic [7:0]       t_byte;
    typedef logic [10:0]      t_ridx;
    typedef logic [FB_AW-1:0] t_fb_addr;
    typedef logic [CNT_W-1:0] t_cnt;

endpackage

// File: design/mibf_ram.sv
// ----------------------------------------------------------------------------
// mibf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mibf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: design/mono_icon_blit_framebuffer.sv
// ----------------------------------------------------------------------------
// mono_icon_blit_framebuffer
// 1bpp icon blitter into a packed msb-first monochrome framebuffer
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready, one transfer per item. mode 0 blits one
//   icon byte (8 pixels, bit 7 first) at the cursor, mode 1 reads one
//   framebuffer byte at i_read_index.
// output channel: o_valid / i_ready, exactly one result transfer per item.
// blit: one framebuffer read-modify-write per on-screen pixel through the
//   single read port of the frame ram, one pixel per cycle; a full byte
//   walks its 8 pixels in ST_BLIT and then waits in ST_FIN for the output
//   register; a byte that completes the icon early leaves ST_BLIT as soon
//   as no pixel is left
// read: fetched at the input transfer, captured in ST_RDWAIT, pushed from ST_FIN.
// the block works on one item at a time; it takes the next item while the
//   previous result still waits, and holds the new result until the
//   receiver takes the old one.
// reset: the frame ram is swept to zero, one byte a cycle over all FB_BYTES
//   bytes (2048 for a 128x128 screen), with o_ready low; cursor and count clear.
// ----------------------------------------------------------------------------
module mono_icon_blit_framebuffer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_mode,
    input  logic            i_start_of_icon,
    input  mibf_pkg::t_pos  i_pos_x,
    input  mibf_pkg::t_pos  i_pos_y,
    input  mibf_pkg::t_dim  i_icon_width,
    input  mibf_pkg::t_dim  i_icon_height,
    input  mibf_pkg::t_byte i_icon_byte,
    input  mibf_pkg::t_ridx i_read_index,
    output logic            o_valid,
    input  logic            i_ready,
    output mibf_pkg::t_byte o_read_data,
    output logic            o_icon_done,
    output logic            o_clipped
);
    import mibf_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_BLIT   = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    logic [2:0] r_state;
    t_fb_addr   r_clr_addr;

    // item held while it is worked on
    logic  r_mode;
    logic  r_rd_oob;
    t_byte r_rd_data;
    t_pos  r_px;
    t_pos  r_py;
    t_dim  r_w;
    t_cnt  r_total;
    t_byte r_byte;
    logic [2:0] r_bit;
    logic  r_clip;

    // cursor state
    logic [7:0] r_cur_x;
    logic [7:0] r_cur_y;
    t_cnt       r_count;

    // write-back stage and forwarding of the last byte written
    logic       r_wb_valid;
    t_fb_addr   r_wb_addr;
    logic [2:0] r_wb_bit;
    logic       r_wb_val;
    logic       r_fw_valid;
    t_fb_addr   r_fw_addr;
    t_byte      r_fw_data;

    // output register
    logic  r_out_valid;
    t_byte r_out_data;
    logic  r_out_done;
    logic  r_out_clip;
    logic  fin_push;

    // frame ram ports
    logic     ram_we;
    t_fb_addr ram_waddr;
    t_byte    ram_wdata;
    logic     ram_re;
    t_fb_addr ram_raddr;
    t_byte    ram_rdata;

    // input decode
    t_dim     w_cl;
    t_dim     h_cl;
    t_cnt     total_in;
    t_fb_addr rd_addr;
    logic     rd_oob;

    // pixel address math
    logic [8:0]  pix_x;
    logic [8:0]  pix_y;
    logic [31:0] lin;
    t_fb_addr    pix_addr;
    logic [2:0]  pix_bit;
    logic        on_screen;
    logic        pix_go;
    logic        wrap;

    t_byte wb_base;
    t_byte wb_new;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_icon_done = r_out_done;
    assign o_clipped   = r_out_clip;

    // finished item moves into the output register once it is free
    assign fin_push = (r_state == ST_FIN) && (!r_out_valid || i_ready);

    // oversized icon dimensions clamp to the max
    assign w_cl = (i_icon_width  > t_dim'(ICON_DIM_MAX)) ? t_dim'(ICON_DIM_MAX) : i_icon_width;
    assign h_cl = (i_icon_height > t_dim'(ICON_DIM_MAX)) ? t_dim'(ICON_DIM_MAX) : i_icon_height;
    assign total_in = CNT_W'(16'(w_cl) * 16'(h_cl));
    assign rd_addr  = FB_AW'(i_read_index);
    assign rd_oob   = (32'(i_read_index) >= 32'(FB_BYTES));

    // screen position of the pixel under the cursor
    assign pix_x     = {2'b00, r_px} + {1'b0, r_cur_x};
    assign pix_y     = {2'b00, r_py} + {1'b0, r_cur_y};
    assign on_screen = (32'(pix_x) < 32'(SCREEN_WIDTH)) && (32'(pix_y) < 32'(SCREEN_HEIGHT));
    assign lin       = 32'(pix_y) * 32'(SCREEN_WIDTH) + 32'(pix_x);
    assign pix_addr  = lin[3 +: FB_AW];
    assign pix_bit   = 3'd7 - lin[2:0];
    assign pix_go    = (r_count < r_total);
    assign wrap      = (({1'b0, r_cur_x} + 9'd1) >= {1'b0, r_w});

    // modify: the byte just written wins over the stale ram read
    always_comb begin
        wb_base = (r_fw_valid && (r_fw_addr == r_wb_addr)) ? r_fw_data : ram_rdata;
        wb_new  = wb_base;
        wb_new[r_wb_bit] = r_wb_val;
    end

    // write port: clearing sweep or pixel write-back
    assign ram_we    = (r_state == ST_CLEAR) || r_wb_valid;
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_wb_addr;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : wb_new;

    // read port: read-mode fetch at the transfer, or pixel fetch in blit
    assign ram_re    = ((r_state == ST_IDLE) && i_valid && (i_mode == MODE_READ))
                    || ((r_state == ST_BLIT) && pix_go && on_screen);
    assign ram_raddr = (r_state == ST_IDLE) ? rd_addr : pix_addr;

    mibf_ram #(
        .WIDTH (8),
        .DEPTH (FB_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_count     <= '0;
            r_wb_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // forwarding register follows the write-back stage
            r_fw_valid <= r_wb_valid;
            r_fw_addr  <= r_wb_addr;
            r_fw_data  <= wb_new;
            // an on-screen pixel fetched now is written back next cycle
            r_wb_valid <= (r_state == ST_BLIT) && pix_go && on_screen;

            if (fin_push) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + t_fb_addr'(1);
                    if (r_clr_addr == FB_AW'(FB_BYTES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_mode   <= i_mode;
                        r_rd_oob <= rd_oob;
                        r_clip   <= 1'b0;
                        r_bit    <= '0;
                        r_byte   <= i_icon_byte;
                        r_px     <= i_pos_x;
                        r_py     <= i_pos_y;
                        r_w      <= w_cl;
                        r_total  <= total_in;
                        if (i_mode == MODE_READ) begin
                            r_state <= ST_RDWAIT;
                        end else begin
                            // new icon restarts the walk
                            if (i_start_of_icon) begin
                                r_cur_x <= '0;
                                r_cur_y <= '0;
                                r_count <= '0;
                            end
                            r_state <= ST_BLIT;
                        end
                    end
                end
                ST_BLIT: begin
                    if (pix_go) begin
                        if (on_screen) begin
                            r_wb_addr  <= pix_addr;
                            r_wb_bit   <= pix_bit;
                            r_wb_val   <= r_byte[7];
                        end else begin
                            r_clip <= 1'b1;
                        end
                        if (wrap) begin
                            r_cur_x <= '0;
                            r_cur_y <= r_cur_y + 8'd1;
                        end else begin
                            r_cur_x <= r_cur_x + 8'd1;
                        end
                        r_count <= r_count + t_cnt'(1);
                        r_byte  <= {r_byte[6:0], 1'b0};
                        r_bit   <= r_bit + 3'd1;
                        if (r_bit == 3'd7) begin
                            r_state <= ST_FIN;
                        end
                    end else begin
                        // icon complete, remaining bits ignored
                        r_state <= ST_FIN;
                    end
                end
                ST_RDWAIT: begin
                    r_rd_data <= ram_rdata;
                    r_state   <= ST_FIN;
                end
                ST_FIN: begin
                    if (fin_push) begin
                        r_out_data  <= ((r_mode == MODE_READ) && !r_rd_oob) ? r_rd_data : '0;
                        r_out_done  <= (r_mode == MODE_BLIT) && (r_count >= r_total);
                        r_out_clip  <= (r_mode == MODE_BLIT) && r_clip;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/mibf_chk.sv
// ----------------------------------------------------------------------------
// mibf_chk
// port-level checks of the icon blitter, bound to the top level
// ----------------------------------------------------------------------------
`include "mono_icon_blit_framebuffer_assert.svh"

module mibf_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input logic            i_mode,
    input logic            i_start_of_icon,
    input mibf_pkg::t_pos  i_pos_x,
    input mibf_pkg::t_pos  i_pos_y,
    input mibf_pkg::t_dim  i_icon_width,
    input mibf_pkg::t_dim  i_icon_height,
    input mibf_pkg::t_byte i_icon_byte,
    input mibf_pkg::t_ridx i_read_index,
    input logic            o_valid,
    input logic            i_ready,
    input mibf_pkg::t_byte o_read_data,
    input logic            o_icon_done,
    input logic            o_clipped
);
    import mibf_pkg::*;

    // nonzero read data only comes from a read, which never flags blit status
    `MIBF_ASSERT_IMP(a_read_has_no_flags, o_valid && (o_read_data != '0), !o_icon_done && !o_clipped, "read result carries blit flags")

    // the clearing sweep follows every reset cycle
    `MIBF_ASSERT_NXT_ANY(a_clear_after_reset, !i_rst_n, !o_ready, "input taken during clearing sweep")

    // one item in flight: no back-to-back input transfers
    `MIBF_ASSERT_NXT(a_one_at_a_time, i_valid && o_ready, !o_ready, "second item taken while busy")

    // a stalled result stays offered
    `MIBF_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_read_data) && $stable(o_icon_done) && $stable(o_clipped), "stalled result dropped or changed")

endmodule

bind mono_icon_blit_framebuffer mibf_chk u_mibf_chk (.*);

// File: verif/tb_mono_icon_blit_framebuffer.sv
// ----------------------------------------------------------------------------
// tb_mono_icon_blit_framebuffer
// self-checking testbench of the 1bpp icon blitter
// ----------------------------------------------------------------------------
// a shadow copy of the framebuffer, the cursor and the pixel count is kept
// in the testbench and stepped on every accepted input transfer. each output
// transfer is compared field by field with the oldest outstanding prediction.
// a short directed table covers the corners of the screen, the icon size
// clamps, zero-sized and finished icons, a width change mid-icon and clipping;
// random icons, reads and noise follow, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_mono_icon_blit_framebuffer;
    timeunit 1ns;
    timeprecision 1ps;

    import mibf_pkg::*;

    localparam int ITEM_TARGET = 1900;
    localparam int DRAIN_CYCLES = 24;

    // one input item, laid out like the port list
    typedef struct packed {
        logic  mode;
        logic  start;
        t_pos  pos_x;
        t_pos  pos_y;
        t_dim  icon_width;
        t_dim  icon_height;
        t_byte icon_byte;
        t_ridx read_index;
    } t_stim;

    // one result item
    typedef struct packed {
        t_byte read_data;
        logic  icon_done;
        logic  clipped;
    } t_outcome;

    // directed row: stimulus plus an optional hand-written result
    typedef struct packed {
        t_stim    stim;
        logic     typed;
        t_outcome fixed;
    } t_dir_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_ready;
    logic     i_mode = MODE_BLIT;
    logic     i_start_of_icon = 1'b0;
    t_pos     i_pos_x = '0;
    t_pos     i_pos_y = '0;
    t_dim     i_icon_width = '0;
    t_dim     i_icon_height = '0;
    t_byte    i_icon_byte = '0;
    t_ridx    i_read_index = '0;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_byte    o_read_data;
    logic     o_icon_done;
    logic     o_clipped;

    // shadow of the block's state
    t_byte       shadow_fb [FB_BYTES];
    logic [7:0]  shadow_cur_x;
    logic [7:0]  shadow_cur_y;
    t_cnt        shadow_px_count;

    t_outcome    outcomes_in_flight [$];
    t_dir_row    directed_rows [$];
    t_outcome    rx_want;

    int n_sent = 0;
    int n_results = 0;
    int n_fail = 0;
    int n_blits = 0;
    int n_reads = 0;
    int n_clipped = 0;
    int n_done = 0;

    mono_icon_blit_framebuffer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_start_of_icon (i_start_of_icon),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_icon_width    (i_icon_width),
        .i_icon_height   (i_icon_height),
        .i_icon_byte     (i_icon_byte),
        .i_read_index    (i_read_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_read_data     (o_read_data),
        .o_icon_done     (o_icon_done),
        .o_clipped       (o_clipped)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // steps the shadow state by one item and returns the result it gives
    function automatic t_outcome compute_item_outcome(input t_stim s);
        t_outcome    r;
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned x;
        int unsigned y;
        int unsigned lin;
        r = '0;
        if (s.mode == MODE_READ) begin
            r.read_data = (s.read_index < FB_BYTES) ? shadow_fb[s.read_index] : '0;
            return r;
        end
        if (s.start) begin
            shadow_cur_x    = '0;
            shadow_cur_y    = '0;
            shadow_px_count = '0;
        end
        // oversized dimensions are clamped, zero gives an empty icon
        w = (s.icon_width > ICON_DIM_MAX) ? ICON_DIM_MAX : s.icon_width;
        h = (s.icon_height > ICON_DIM_MAX) ? ICON_DIM_MAX : s.icon_height;
        total = w * h;
        for (int b = 0; b < 8; b++) begin
            // bits past the end of the icon are ignored
            if (shadow_px_count < total) begin
                x = s.pos_x + shadow_cur_x;
                y = s.pos_y + shadow_cur_y;
                if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) begin
                    r.clipped = 1'b1;
                end else begin
                    lin = y * SCREEN_WIDTH + x;
                    shadow_fb[t_fb_addr'(lin >> 3)][3'(7 - (lin & 7))] =
                        s.icon_byte[3'(7 - b)];
                end
                // wrap at the right edge, also when the width shrank mid-icon
                if (shadow_cur_x + 1 >= w) begin
                    shadow_cur_x = '0;
                    shadow_cur_y = shadow_cur_y + 8'd1;
                end else begin
                    shadow_cur_x = shadow_cur_x + 8'd1;
                end
                shadow_px_count = shadow_px_count + t_cnt'(1);
            end
        end
        r.icon_done = (shadow_px_count >= total);
        return r;
    endfunction

    // read item, the unused fields carry random junk
    function automatic t_stim read_of(input t_ridx idx);
        logic [63:0] raw;
        t_stim       s;
        raw = {$urandom, $urandom};
        s = raw[$bits(t_stim)-1:0];
        s.mode = MODE_READ;
        s.read_index = idx;
        return s;
    endfunction

    function automatic t_stim blit_of(input logic st, input t_pos x, input t_pos y,
                                      input t_dim w, input t_dim h, input t_byte d);
        t_stim s;
        s.mode        = MODE_BLIT;
        s.start       = st;
        s.pos_x       = x;
        s.pos_y       = y;
        s.icon_width  = w;
        s.icon_height = h;
        s.icon_byte   = d;
        s.read_index  = t_ridx'($urandom);
        return s;
    endfunction

    function automatic void add_row(input t_stim s, input logic typed, input t_outcome fixed);
        t_dir_row row;
        row.stim  = s;
        row.typed = typed;
        row.fixed = fixed;
        directed_rows.push_back(row);
    endfunction

    // drives one item and holds it until the transfer, then records the prediction
    task automatic send_item(input t_stim s, input logic typed, input t_outcome fixed);
        t_outcome pred;
        i_valid         <= 1'b1;
        i_mode          <= s.mode;
        i_start_of_icon <= s.start;
        i_pos_x         <= s.pos_x;
        i_pos_y         <= s.pos_y;
        i_icon_width    <= s.icon_width;
        i_icon_height   <= s.icon_height;
        i_icon_byte     <= s.icon_byte;
        i_read_index    <= s.read_index;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred = compute_item_outcome(s);
        outcomes_in_flight.push_back(typed ? fixed : pred);
        n_sent++;
        if (s.mode == MODE_READ) begin
            n_reads++;
        end else begin
            n_blits++;
            if (pred.clipped) n_clipped++;
            if (pred.icon_done) n_done++;
        end
    endtask

    // random sender gaps of varying length, none in the quiet window
    task automatic next_item(input t_stim s);
        if (!(n_sent >= 500 && n_sent < 900) && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        send_item(s, 1'b0, '0);
    endtask

    // hold off the sender until every result is back
    task automatic drain_outcomes();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outcomes_in_flight.size() != 0);
    endtask

    // one icon as a byte stream, with stray reads, width changes and early cuts
    task automatic send_icon();
        t_stim       s;
        int unsigned pick;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned nbytes;
        int unsigned base;
        s = blit_of(1'b1, 0, 0, 1, 1, 0);
        pick = $urandom_range(99);
        if (pick < 80) begin
            s.icon_width  = t_dim'($urandom_range(1, 24));
            s.icon_height = t_dim'($urandom_range(1, 12));
        end else if (pick < 90) begin
            s.icon_width  = t_dim'($urandom_range(100, 255));
            s.icon_height = t_dim'($urandom_range(1, 2));
        end else if (pick < 95) begin
            s.icon_width  = t_dim'($urandom_range(1, 2));
            s.icon_height = t_dim'($urandom_range(1, 255));
        end else begin
            // empty icon
            s.icon_width  = $urandom_range(0, 1) ? 8'd0 : t_dim'($urandom);
            s.icon_height = (s.icon_width != 0) ? 8'd0 : t_dim'($urandom);
        end
        w_eff = (s.icon_width > ICON_DIM_MAX) ? ICON_DIM_MAX : s.icon_width;
        h_eff = (s.icon_height > ICON_DIM_MAX) ? ICON_DIM_MAX : s.icon_height;
        if ($urandom_range(1) == 1 && w_eff > 0 && h_eff > 0) begin
            s.pos_x = t_pos'($urandom_range(0, SCREEN_WIDTH - w_eff));
            s.pos_y = t_pos'($urandom_range(0, SCREEN_HEIGHT - h_eff));
        end else begin
            s.pos_x = t_pos'($urandom);
            s.pos_y = t_pos'($urandom);
        end
        nbytes = (w_eff * h_eff + 7) / 8;
        if (nbytes == 0) nbytes = 1;
        nbytes += $urandom_range(0, 1);
        if ($urandom_range(99) < 5) nbytes = $urandom_range(1, nbytes);
        for (int k = 0; k < nbytes; k++) begin
            s.start      = (k == 0);
            s.icon_byte  = t_byte'($urandom);
            s.read_index = t_ridx'($urandom);
            if (k > 0 && $urandom_range(99) < 5) s.icon_width = t_dim'($urandom_range(1, 255));
            next_item(s);
            if ($urandom_range(99) < 15) next_item(read_of(t_ridx'($urandom)));
        end
        // look at what landed on screen
        base = (s.pos_y * SCREEN_WIDTH + s.pos_x) / 8;
        repeat ($urandom_range(1, 3)) begin
            next_item(read_of(t_ridx'(base + 16 * $urandom_range(0, h_eff) +
                                      $urandom_range(0, 2))));
        end
    endtask

    // result side: check every output transfer, stall ready at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (outcomes_in_flight.size() == 0) begin
                $error("result transfer with no item outstanding");
                n_fail++;
            end else begin
                rx_want = outcomes_in_flight.pop_front();
                if (o_read_data !== rx_want.read_data) begin
                    $error("read_data: expected %02h, got %02h", rx_want.read_data, o_read_data);
                    n_fail++;
                end
                if (o_icon_done !== rx_want.icon_done) begin
                    $error("icon_done: expected %0b, got %0b", rx_want.icon_done, o_icon_done);
                    n_fail++;
                end
                if (o_clipped !== rx_want.clipped) begin
                    $error("clipped: expected %0b, got %0b", rx_want.clipped, o_clipped);
                    n_fail++;
                end
            end
        end
        // no stalls while the quiet window lasts
        i_ready <= (n_results >= 1000 && n_results < 1400) || ($urandom_range(99) >= 7);
    end

    // run limit, far beyond reset sweep plus the slowest legal run
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        foreach (shadow_fb[i]) shadow_fb[i] = '0;
        shadow_cur_x    = '0;
        shadow_cur_y    = '0;
        shadow_px_count = '0;

        // directed table
        // screen cleared after reset, first and last byte
        add_row(read_of(11'd0), 1'b1, {8'h00, 1'b0, 1'b0});
        add_row(read_of(11'd2047), 1'b1, {8'h00, 1'b0, 1'b0});
        // top left corner, one full byte
        add_row(blit_of(1'b1, 0, 0, 8, 1, 8'hFF), 1'b1, {8'h00, 1'b1, 1'b0});
        add_row(read_of(11'd0), 1'b1, {8'hFF, 1'b0, 1'b0});
        // bottom right pixel
        add_row(blit_of(1'b1, 127, 127, 1, 1, 8'h80), 1'b1, {8'h00, 1'b1, 1'b0});
        add_row(read_of(11'd2047), 1'b1, {8'h01, 1'b0, 1'b0});
        // bottom right pixel cleared, the one right of it falls off
        add_row(blit_of(1'b1, 127, 127, 2, 1, 8'h00), 1'b1, {8'h00, 1'b1, 1'b1});
        add_row(read_of(11'd2047), 1'b1, {8'h00, 1'b0, 1'b0});
        // zero width and zero height
        add_row(blit_of(1'b1, 5, 5, 0, 5, 8'hFF), 1'b1, {8'h00, 1'b1, 1'b0});
        add_row(blit_of(1'b1, 5, 5, 7, 0, 8'hFF), 1'b1, {8'h00, 1'b1, 1'b0});
        // oversized icon clamps to full screen, row 8 starts at byte 128
        add_row(blit_of(1'b1, 0, 8, 255, 255, 8'hA5), 1'b1, {8'h00, 1'b0, 1'b0});
        add_row(read_of(11'd128), 1'b1, {8'hA5, 1'b0, 1'b0});
        add_row(blit_of(1'b0, 0, 8, 200, 130, 8'h5A), 1'b0, '0);
        add_row(read_of(11'd129), 1'b0, '0);
        // icon already complete, later bytes change nothing
        add_row(blit_of(1'b1, 10, 20, 3, 2, 8'hFF), 1'b1, {8'h00, 1'b1, 1'b0});
        add_row(blit_of(1'b0, 10, 20, 3, 2, 8'h00), 1'b1, {8'h00, 1'b1, 1'b0});
        add_row(read_of(11'd321), 1'b0, '0);
        // width shrinks while the cursor is past the new edge
        add_row(blit_of(1'b1, 40, 40, 16, 4, 8'hF0), 1'b0, '0);
        add_row(blit_of(1'b0, 40, 40, 4, 4, 8'h0F), 1'b0, '0);
        add_row(read_of(11'd645), 1'b0, '0);
        add_row(read_of(11'd661), 1'b0, '0);
        // icon hanging off the bottom edge, a read in between keeps the cursor
        add_row(blit_of(1'b1, 120, 127, 8, 3, 8'hFF), 1'b0, '0);
        add_row(blit_of(1'b0, 120, 127, 8, 3, 8'hFF), 1'b0, '0);
        add_row(read_of(11'd2047), 1'b0, '0);
        add_row(blit_of(1'b0, 120, 127, 8, 3, 8'h00), 1'b0, '0);
        add_row(read_of(11'd2047), 1'b0, '0);

        // synchronous reset, then the frame sweep holds o_ready low
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if ($urandom_range(99) < 10) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].fixed);
        end
        drain_outcomes();

        // random part: mostly whole icons, some plain reads and noise
        while (n_sent < ITEM_TARGET) begin
            if ($urandom_range(99) < 2) drain_outcomes();
            case ($urandom_range(9))
                0, 1: next_item(read_of(t_ridx'($urandom)));
                2: next_item(t_stim'({$urandom, $urandom} >> (64 - $bits(t_stim))));
                default: send_icon();
            endcase
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (outcomes_in_flight.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d blit and %0d read transfers, %0d results checked",
                 n_blits, n_reads, n_results);
        $display("%0d blits clipped, %0d blits ended a complete icon", n_clipped, n_done);
        if (n_fail == 0 && outcomes_in_flight.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
